@@ design/moa_pkg.sv @@
`default_nettype none
package moa_pkg;

    // configuration of the filter
    localparam int CHANNELS    = 2;
    localparam int AVG_SHIFT   = 3;
    localparam int SAMPLE_BITS = 12;

    // field widths on the ports
    localparam int RAW_W  = 12;
    localparam int CHAN_W = 4;
    localparam int AVG_W  = 12;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;
    localparam int OUT_TUSER_W = 4;

    // derived sizes
    localparam int RING   = (1 << AVG_SHIFT) + 2;
    localparam int HIST_W = (SAMPLE_BITS < RAW_W) ? SAMPLE_BITS : RAW_W;
    localparam int SUM_W  = HIST_W + $clog2(RING + 1) + 1;
    localparam int SLOT_W = $clog2(RING);
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef logic [HIST_W-1:0] sample_t;
    typedef logic [SUM_W-1:0]  sum_t;
    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [CH_W-1:0]   ch_t;
    typedef logic [CHAN_W-1:0] chan_out_t;
    typedef logic [AVG_W-1:0]  avg_t;

    localparam slot_t SLOT_ZERO = slot_t'(0);
    localparam slot_t SLOT_ONE  = slot_t'(1);
    localparam slot_t SLOT_LAST = slot_t'(RING - 1);
    localparam ch_t   CH_ZERO   = ch_t'(0);
    localparam ch_t   CH_ONE    = ch_t'(1);
    localparam ch_t   CH_LAST   = ch_t'(CHANNELS - 1);

    // controller to datapath
    typedef struct packed {
        logic start;   // take the request, store the sample
        logic step;    // fold one ring slot into sum, min, max
        logic finish;  // load the output register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic last_slot;  // the walk is at the final slot
        logic out_free;   // output register can take a result now
    } status_t;

endpackage
`default_nettype wire

@@ design/multichannel_olympic_average_unit.sv @@
`default_nettype none
// channel   | dir | tdata                          | tuser
// s_axis    | in  | [11:0] raw_sample              | -
// m_axis    | out | [11:0] average                 | [3:0] channel
//
// a request is handled in order: store the sample, walk the ring slot by slot
// (10 slots) with a single read port, and load the result
// a new request is taken as soon as the result is loaded, even if it has
// not yet been taken downstream; the result load, and with it the next
// request, waits only while an earlier result still sits unaccepted
// reset (rst_n low, asynchronous) clears the whole history, write positions
// and the channel pointer
module multichannel_olympic_average_unit (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire [moa_pkg::IN_TDATA_W-1:0]      s_axis_tdata,   // [11:0] raw_sample
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    output logic [moa_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,   // [11:0] average
    output logic [moa_pkg::OUT_TUSER_W-1:0]    m_axis_tuser    // [3:0] channel
);

    moa_pkg::cmd_t      cmd;
    moa_pkg::status_t   status;
    moa_pkg::avg_t      average;
    moa_pkg::chan_out_t channel;

    // sequencer
    moa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // history, walk and output register
    moa_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .raw_sample  (s_axis_tdata[moa_pkg::RAW_W-1:0]),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_channel (channel),
        .out_average (average)
    );

    assign m_axis_tdata = moa_pkg::OUT_TDATA_W'(average);
    assign m_axis_tuser = channel;

    // no new request while the ring walk is running
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken during ring walk");

    // a result is only loaded when the output register is free
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result overwrote a pending result");

    // reported channel is a served channel
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser <= moa_pkg::CHAN_W'(moa_pkg::CHANNELS - 1)))
        else $error("channel out of range");

    // only one command at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.start, cmd.step, cmd.finish}))
        else $error("conflicting datapath commands");

endmodule
`default_nettype wire

@@ design/moa_ctrl.sv @@
`default_nettype none
module moa_ctrl (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              in_valid,
    output logic             in_ready,
    input  moa_pkg::status_t status,
    output moa_pkg::cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                cmd.step = 1'b1;
                if (status.last_slot)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

@@ design/moa_dp.sv @@
`default_nettype none
module moa_dp (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  moa_pkg::cmd_t                        cmd,
    output moa_pkg::status_t                     status,
    input  wire [moa_pkg::RAW_W-1:0]             raw_sample,
    output logic                                 out_valid,
    input  wire                                  out_ready,
    output logic [moa_pkg::CHAN_W-1:0]           out_channel,
    output logic [moa_pkg::AVG_W-1:0]            out_average
);

    moa_pkg::sample_t hist_reg [moa_pkg::CHANNELS][moa_pkg::RING];
    moa_pkg::slot_t   wslot_reg [moa_pkg::CHANNELS];
    moa_pkg::ch_t     chptr_reg;
    moa_pkg::ch_t     cur_ch_reg;
    moa_pkg::slot_t   idx_reg;
    moa_pkg::sum_t    sum_reg;
    moa_pkg::sample_t lo_reg;
    moa_pkg::sample_t hi_reg;
    logic             out_valid_reg;
    moa_pkg::chan_out_t out_ch_reg;
    moa_pkg::avg_t    out_avg_reg;

    moa_pkg::slot_t   slot_next;
    moa_pkg::ch_t     chptr_next;
    moa_pkg::sample_t rd_val;
    moa_pkg::sum_t    trimmed;

    // write position and channel advance
    always_comb
    begin
        if (wslot_reg[chptr_reg] == moa_pkg::SLOT_LAST)
        begin
            slot_next = moa_pkg::SLOT_ZERO;
        end
        else
        begin
            slot_next = wslot_reg[chptr_reg] + moa_pkg::SLOT_ONE;
        end
        if (chptr_reg == moa_pkg::CH_LAST)
        begin
            chptr_next = moa_pkg::CH_ZERO;
        end
        else
        begin
            chptr_next = chptr_reg + moa_pkg::CH_ONE;
        end
    end

    // ring read for the walk and the trimmed sum
    assign rd_val  = hist_reg[cur_ch_reg][idx_reg];
    assign trimmed = sum_reg - moa_pkg::sum_t'(lo_reg) - moa_pkg::sum_t'(hi_reg);

    assign status.last_slot = (idx_reg == moa_pkg::SLOT_LAST);
    assign status.out_free  = !out_valid_reg || out_ready;

    // sample history, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < moa_pkg::CHANNELS; c++)
            begin
                for (int s = 0; s < moa_pkg::RING; s++)
                begin
                    hist_reg[c][s] <= '0;
                end
                wslot_reg[c] <= moa_pkg::SLOT_ZERO;
            end
            chptr_reg <= moa_pkg::CH_ZERO;
        end
        else if (cmd.start)
        begin
            hist_reg[chptr_reg][slot_next] <= moa_pkg::sample_t'(raw_sample);
            wslot_reg[chptr_reg]           <= slot_next;
            chptr_reg                      <= chptr_next;
        end
    end

    // walk over the ring: sum, minimum, maximum
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            cur_ch_reg <= chptr_reg;
            idx_reg    <= moa_pkg::SLOT_ZERO;
        end
        else if (cmd.step)
        begin
            if (idx_reg == moa_pkg::SLOT_ZERO)
            begin
                sum_reg <= moa_pkg::sum_t'(rd_val);
                lo_reg  <= rd_val;
                hi_reg  <= rd_val;
            end
            else
            begin
                sum_reg <= sum_reg + moa_pkg::sum_t'(rd_val);
                if (rd_val < lo_reg)
                begin
                    lo_reg <= rd_val;
                end
                if (rd_val > hi_reg)
                begin
                    hi_reg <= rd_val;
                end
            end
            if (idx_reg != moa_pkg::SLOT_LAST)
            begin
                idx_reg <= idx_reg + moa_pkg::SLOT_ONE;
            end
        end
    end

    // output register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_ch_reg  <= moa_pkg::chan_out_t'(cur_ch_reg);
            out_avg_reg <= moa_pkg::avg_t'(trimmed >> moa_pkg::AVG_SHIFT);
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_channel = out_ch_reg;
    assign out_average = out_avg_reg;

endmodule
`default_nettype wire
